[hw/rtl/fmpf_pkg.sv]
// ----------------------------------------------------------------------------
// fmpf_pkg
// Shared types and constants of the first-match packet filter.
// ----------------------------------------------------------------------------
package fmpf_pkg;

  // Default number of rules the table can hold.
  localparam int unsigned RuleDepthDefault = 64;

  // IP protocol number of ICMP; ports are not compared for it.
  localparam logic [7:0] ProtoIcmp = 8'd1;

  // Command codes as they arrive on the cmd port.
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_CHECK  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // Operation the back end carries out for one queued beat.
  typedef enum logic [1:0] {
    OP_NOP,
    OP_CLEAR,
    OP_APPEND,
    OP_CHECK
  } op_e;

  // Back end sequencer states.
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_e;

  // One rule as stored in the table, or one packet to be checked.
  typedef struct packed {
    logic        action;
    logic        proto_any;
    logic [7:0]  proto;
    logic        dport_any;
    logic [15:0] dport;
    logic        sport_any;
    logic [15:0] sport;
    logic        dst_addr_any;
    logic [31:0] dst_addr;
    logic        src_addr_any;
    logic [31:0] src_addr;
  } rule_t;

  // One queued beat between front and back end.
  typedef struct packed {
    op_e   op;
    rule_t rule;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic matched;
    logic verdict;
    logic status;
  } result_t;

endpackage

[hw/rtl/first_match_packet_filter_unit.sv]
// ----------------------------------------------------------------------------
// first_match_packet_filter_unit
// Ordered first-match five-tuple rule table with clear, append and check.
// ----------------------------------------------------------------------------
// With the back end idle: clear, append and unused commands return their
// result beat from the result register after the queue entry; a check reads
// the stored rules in order, one stored rule read per cycle, until one hits.
// Throughput: while no check is being scanned, the back end retires a clear or
// append every cycle; busy_o is high only while the queue is full.
// Reset empties the queue and the rule table; the receiver cannot stall.
// ----------------------------------------------------------------------------
module first_match_packet_filter_unit #(
  parameter int unsigned RuleDepth = fmpf_pkg::RuleDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] src_addr_i,
  input  logic        src_addr_any_i,
  input  logic [31:0] dst_addr_i,
  input  logic        dst_addr_any_i,
  input  logic [15:0] sport_i,
  input  logic        sport_any_i,
  input  logic [15:0] dport_i,
  input  logic        dport_any_i,
  input  logic [7:0]  protocol_i,
  input  logic        protocol_any_i,
  input  logic        rule_action_i,
  output logic        result_valid_o,
  output logic        matched_o,
  output logic        verdict_o,
  output logic        status_o
);

  // The front end turns each accepted command beat into a queued operation.
  // The queue lets the front keep accepting beats while the back end scans.
  // The back end owns the rule table and produces one result beat per
  // operation, strictly in arrival order.

  logic              push;
  logic              pop;
  logic              full;
  logic              empty;
  fmpf_pkg::item_t   item;
  fmpf_pkg::item_t   head;
  fmpf_pkg::result_t res;

  fmpf_front u_front (
    .start_i        (start_i),
    .full_i         (full),
    .cmd_i          (cmd_i),
    .src_addr_i     (src_addr_i),
    .src_addr_any_i (src_addr_any_i),
    .dst_addr_i     (dst_addr_i),
    .dst_addr_any_i (dst_addr_any_i),
    .sport_i        (sport_i),
    .sport_any_i    (sport_any_i),
    .dport_i        (dport_i),
    .dport_any_i    (dport_any_i),
    .protocol_i     (protocol_i),
    .protocol_any_i (protocol_any_i),
    .rule_action_i  (rule_action_i),
    .busy_o         (busy_o),
    .push_o         (push),
    .item_o         (item)
  );

  fmpf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  fmpf_back #(
    .RuleDepth (RuleDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .res_valid_o (result_valid_o),
    .res_o       (res)
  );

  // Each result beat is shown for exactly one cycle.
  assign matched_o = res.matched;
  assign verdict_o = res.verdict;
  assign status_o  = res.status;

endmodule

[hw/rtl/fmpf_front.sv]
// ----------------------------------------------------------------------------
// fmpf_front
// Accepts command beats and classifies them into queued operations.
// ----------------------------------------------------------------------------
module fmpf_front (
  input  logic                start_i,
  input  logic                full_i,
  input  logic [1:0]          cmd_i,
  input  logic [31:0]         src_addr_i,
  input  logic                src_addr_any_i,
  input  logic [31:0]         dst_addr_i,
  input  logic                dst_addr_any_i,
  input  logic [15:0]         sport_i,
  input  logic                sport_any_i,
  input  logic [15:0]         dport_i,
  input  logic                dport_any_i,
  input  logic [7:0]          protocol_i,
  input  logic                protocol_any_i,
  input  logic                rule_action_i,
  output logic                busy_o,
  output logic                push_o,
  output fmpf_pkg::item_t     item_o
);

  assign busy_o = full_i;
  assign push_o = start_i && !full_i;

  always_comb begin
    item_o.rule.action       = rule_action_i;
    item_o.rule.proto_any    = protocol_any_i;
    item_o.rule.proto        = protocol_i;
    item_o.rule.dport_any    = dport_any_i;
    item_o.rule.dport        = dport_i;
    item_o.rule.sport_any    = sport_any_i;
    item_o.rule.sport        = sport_i;
    item_o.rule.dst_addr_any = dst_addr_any_i;
    item_o.rule.dst_addr     = dst_addr_i;
    item_o.rule.src_addr_any = src_addr_any_i;
    item_o.rule.src_addr     = src_addr_i;
    unique case (fmpf_pkg::cmd_e'(cmd_i))
      fmpf_pkg::CMD_CLEAR:  item_o.op = fmpf_pkg::OP_CLEAR;
      fmpf_pkg::CMD_APPEND: item_o.op = fmpf_pkg::OP_APPEND;
      fmpf_pkg::CMD_CHECK:  item_o.op = fmpf_pkg::OP_CHECK;
      default:              item_o.op = fmpf_pkg::OP_NOP;
    endcase
  end

endmodule

[hw/rtl/fmpf_queue.sv]
// ----------------------------------------------------------------------------
// fmpf_queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module fmpf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  fmpf_pkg::item_t item_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output fmpf_pkg::item_t head_o
);

  fmpf_pkg::item_t entry_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[hw/rtl/fmpf_back.sv]
// ----------------------------------------------------------------------------
// fmpf_back
// Rule table memory and the sequencer that clears, appends and scans it.
// ----------------------------------------------------------------------------
module fmpf_back #(
  parameter int unsigned RuleDepth = fmpf_pkg::RuleDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  fmpf_pkg::item_t   head_i,
  output logic              pop_o,
  output logic              res_valid_o,
  output fmpf_pkg::result_t res_o
);

  localparam int unsigned AddrW = (RuleDepth > 1) ? $clog2(RuleDepth) : 1;
  localparam int unsigned CntW  = $clog2(RuleDepth + 1);

  fmpf_pkg::rule_t   table_q [RuleDepth];
  fmpf_pkg::rule_t   rd_data_q;
  fmpf_pkg::rule_t   pkt_q, pkt_d;
  fmpf_pkg::state_e  state_q, state_d;
  fmpf_pkg::result_t res_q, res_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic              rd_valid_q;
  logic              res_valid_q, res_valid_d;
  logic              wr_en;
  logic              issue;
  logic              hit;
  logic              scan_done;
  logic              table_full;

  assign table_full = (count_q == CntW'(RuleDepth));
  assign issue      = (state_q == fmpf_pkg::ST_SCAN) && (idx_q < count_q);

  // Compare the rule read last cycle against the packet under check.
  always_comb begin
    logic sa_ok, da_ok, pr_ok, sp_ok, dp_ok, icmp;
    sa_ok = rd_data_q.src_addr_any || (rd_data_q.src_addr == pkt_q.src_addr);
    da_ok = rd_data_q.dst_addr_any || (rd_data_q.dst_addr == pkt_q.dst_addr);
    pr_ok = rd_data_q.proto_any || (rd_data_q.proto == pkt_q.proto);
    sp_ok = rd_data_q.sport_any || (rd_data_q.sport == pkt_q.sport);
    dp_ok = rd_data_q.dport_any || (rd_data_q.dport == pkt_q.dport);
    icmp  = (pkt_q.proto == fmpf_pkg::ProtoIcmp);
    hit   = sa_ok && da_ok && pr_ok && (icmp || (sp_ok && dp_ok));
  end

  assign scan_done = !issue || (rd_valid_q && hit);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fmpf_pkg::ST_IDLE: begin
        if (!empty_i && (head_i.op == fmpf_pkg::OP_CHECK)) begin
          state_d = fmpf_pkg::ST_SCAN;
        end
      end
      fmpf_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = fmpf_pkg::ST_IDLE;
        end
      end
      default: state_d = fmpf_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    pop_o       = 1'b0;
    wr_en       = 1'b0;
    count_d     = count_q;
    idx_d       = idx_q;
    pkt_d       = pkt_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    unique case (state_q)
      fmpf_pkg::ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          unique case (head_i.op)
            fmpf_pkg::OP_CLEAR: begin
              count_d     = '0;
              res_valid_d = 1'b1;
            end
            fmpf_pkg::OP_APPEND: begin
              res_valid_d = 1'b1;
              if (table_full) begin
                res_d.status = 1'b1;
              end else begin
                wr_en   = 1'b1;
                count_d = CntW'(count_q + 1'b1);
              end
            end
            fmpf_pkg::OP_CHECK: begin
              pkt_d = head_i.rule;
              idx_d = '0;
            end
            default: res_valid_d = 1'b1;
          endcase
        end
      end
      fmpf_pkg::ST_SCAN: begin
        if (issue) begin
          idx_d = CntW'(idx_q + 1'b1);
        end
        if (scan_done) begin
          res_valid_d   = 1'b1;
          res_d.matched = rd_valid_q && hit;
          res_d.verdict = rd_valid_q && hit && rd_data_q.action;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fmpf_pkg::ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      rd_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      rd_valid_q  <= issue;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pkt_q <= pkt_d;
    res_q <= res_d;
  end

  // Rule table: one write port for appends, one registered read port for scans.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_q[count_q[AddrW-1:0]] <= head_i.rule;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_data_q <= table_q[idx_q[AddrW-1:0]];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(RuleDepth))
    else $error("rule count exceeds table depth");

  a_no_pop_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fmpf_pkg::ST_SCAN) |-> !pop_o)
    else $error("queue popped during a scan");

  a_read_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> $past(state_q == fmpf_pkg::ST_SCAN))
    else $error("table read outside a scan");

  a_status_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.status) |-> !res_q.matched)
    else $error("full flag together with a match");

  a_verdict_needs_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.verdict) |-> res_q.matched)
    else $error("drop verdict without a match");

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-match packet filter: a directed table of
// commands, then random rule sets of varied size, every result beat compared
// with a hand-written value or with a behavioral rule table kept inside the bench.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RuleDepth    = fmpf_pkg::RuleDepthDefault;
  localparam int unsigned RandomItems  = 900;
  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned MaxReported  = 10;
  localparam logic [7:0]  ProtoTcp     = 8'd6;
  localparam logic [7:0]  ProtoUdp     = 8'd17;

  // Result beats whose value can be read straight off the command.
  localparam fmpf_pkg::result_t NoHit     = '0;
  localparam fmpf_pkg::result_t HitDrop   = '{matched: 1'b1, verdict: 1'b1, status: 1'b0};
  localparam fmpf_pkg::result_t TableFull = '{matched: 1'b0, verdict: 1'b0, status: 1'b1};

  // One row of the directed table. When typed is set, want holds the result
  // beat written in by hand; otherwise the behavioral table supplies it.
  typedef struct {
    fmpf_pkg::cmd_e    cmd;
    fmpf_pkg::rule_t   pkt;
    bit                typed;
    fmpf_pkg::result_t want;
  } plan_entry_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  cmd_i = fmpf_pkg::CMD_NONE;
  logic [31:0] src_addr_i = '0;
  logic        src_addr_any_i = 1'b0;
  logic [31:0] dst_addr_i = '0;
  logic        dst_addr_any_i = 1'b0;
  logic [15:0] sport_i = '0;
  logic        sport_any_i = 1'b0;
  logic [15:0] dport_i = '0;
  logic        dport_any_i = 1'b0;
  logic [7:0]  protocol_i = '0;
  logic        protocol_any_i = 1'b0;
  logic        rule_action_i = 1'b0;
  logic        result_valid_o;
  logic        matched_o;
  logic        verdict_o;
  logic        status_o;

  // Behavioral copy of the rule table. Only entries below rule_total are ever
  // looked at, exactly as in the block, so stale entries left after a clear
  // never matter.
  fmpf_pkg::rule_t   rule_table [RuleDepth];
  int unsigned       rule_total = 0;

  // Result beats still owed by the block, oldest first.
  fmpf_pkg::result_t pending_verdicts [$];
  int unsigned       mismatch_total = 0;
  int unsigned       cycle_count = 0;

  // When cleared, the sender runs back to back for a whole stretch.
  bit          idle_on = 1'b1;

  first_match_packet_filter_unit #(
    .RuleDepth(RuleDepth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .src_addr_i     (src_addr_i),
    .src_addr_any_i (src_addr_any_i),
    .dst_addr_i     (dst_addr_i),
    .dst_addr_any_i (dst_addr_any_i),
    .sport_i        (sport_i),
    .sport_any_i    (sport_any_i),
    .dport_i        (dport_i),
    .dport_any_i    (dport_any_i),
    .protocol_i     (protocol_i),
    .protocol_any_i (protocol_any_i),
    .rule_action_i  (rule_action_i),
    .result_valid_o (result_valid_o),
    .matched_o      (matched_o),
    .verdict_o      (verdict_o),
    .status_o       (status_o)
  );

  always #1 clk_i = ~clk_i;

  // Builds a rule (or a packet, whose wildcard and action bits the block
  // ignores on a check) from its fields.
  function automatic fmpf_pkg::rule_t mk_rule(logic [31:0] sa, logic sa_any,
                                              logic [31:0] da, logic da_any,
                                              logic [15:0] sp, logic sp_any,
                                              logic [15:0] dp, logic dp_any,
                                              logic [7:0] pr, logic pr_any,
                                              logic act);
    fmpf_pkg::rule_t r;
    r.src_addr     = sa;
    r.src_addr_any = sa_any;
    r.dst_addr     = da;
    r.dst_addr_any = da_any;
    r.sport        = sp;
    r.sport_any    = sp_any;
    r.dport        = dp;
    r.dport_any    = dp_any;
    r.proto        = pr;
    r.proto_any    = pr_any;
    r.action       = act;
    return r;
  endfunction

  function automatic plan_entry_t plan_entry(fmpf_pkg::cmd_e c, fmpf_pkg::rule_t p,
                                             bit typed, fmpf_pkg::result_t want);
    plan_entry_t e;
    e.cmd   = c;
    e.pkt   = p;
    e.typed = typed;
    e.want  = want;
    return e;
  endfunction

  // Carries one accepted command through the behavioral table and returns
  // the result beat it must produce. A check walks the valid rules in order
  // and stops at the first one whose every non-wildcard field agrees with the
  // packet; ports are skipped when the packet is ICMP.
  function automatic fmpf_pkg::result_t classify_beat(fmpf_pkg::cmd_e c,
                                                      fmpf_pkg::rule_t pkt);
    fmpf_pkg::result_t res;
    fmpf_pkg::rule_t   r;
    bit                hit;
    res = '0;
    case (c)
      fmpf_pkg::CMD_CLEAR: begin
        rule_total = 0;
      end
      fmpf_pkg::CMD_APPEND: begin
        if (rule_total >= RuleDepth) begin
          res.status = 1'b1;
        end else begin
          rule_table[rule_total] = pkt;
          rule_total++;
        end
      end
      fmpf_pkg::CMD_CHECK: begin
        for (int unsigned i = 0; i < rule_total; i++) begin
          r = rule_table[i];
          hit = (r.src_addr_any || r.src_addr == pkt.src_addr) &&
                (r.dst_addr_any || r.dst_addr == pkt.dst_addr) &&
                (r.proto_any || r.proto == pkt.proto) &&
                (pkt.proto == fmpf_pkg::ProtoIcmp ||
                 ((r.sport_any || r.sport == pkt.sport) &&
                  (r.dport_any || r.dport == pkt.dport)));
          if (hit && !res.matched) begin
            res.matched = 1'b1;
            res.verdict = r.action;
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Field pickers lean towards a few shared values so that rules overlap and
  // the order of the table decides the verdict.
  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return 32'h0A00_0000 | $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'd80;
      3:       return 16'd443;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(0, 4))
      0:       return fmpf_pkg::ProtoIcmp;
      1:       return ProtoTcp;
      2:       return ProtoUdp;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic pick_any();
    return ($urandom_range(0, 3) == 0);
  endfunction

  function automatic fmpf_pkg::rule_t random_rule();
    return mk_rule(pick_addr(), pick_any(), pick_addr(), pick_any(), pick_port(),
                   pick_any(), pick_port(), pick_any(), pick_proto(), pick_any(),
                   1'($urandom));
  endfunction

  // A packet built from one stored rule: wildcard fields get random values
  // and, now and then, one field is knocked off so that the scan must go on
  // to a later rule or miss altogether.
  function automatic fmpf_pkg::rule_t packet_near_rule();
    fmpf_pkg::rule_t p;
    fmpf_pkg::rule_t noise;
    p = rule_table[$urandom_range(0, rule_total - 1)];
    noise = random_rule();
    if (p.src_addr_any) p.src_addr = noise.src_addr;
    if (p.dst_addr_any) p.dst_addr = noise.dst_addr;
    if (p.sport_any)    p.sport    = noise.sport;
    if (p.dport_any)    p.dport    = noise.dport;
    if (p.proto_any)    p.proto    = noise.proto;
    if ($urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 5))
        0:       p.src_addr = pick_addr();
        1:       p.dst_addr = pick_addr();
        2:       p.sport    = pick_port();
        3:       p.dport    = pick_port();
        4:       p.proto    = pick_proto();
        default: p.proto    = fmpf_pkg::ProtoIcmp;
      endcase
    end
    // Wildcard and action bits carry no meaning on a check; toggle them freely.
    p.src_addr_any = noise.src_addr_any;
    p.dst_addr_any = noise.dst_addr_any;
    p.sport_any    = noise.sport_any;
    p.dport_any    = noise.dport_any;
    p.proto_any    = noise.proto_any;
    p.action       = noise.action;
    return p;
  endfunction

  // Drives one command beat and returns at the edge that accepts it. The
  // caller is always parked on a rising edge, so with a zero gap start_i just
  // stays high and only the payload changes in that step.
  task automatic send_beat(fmpf_pkg::cmd_e c, fmpf_pkg::rule_t p, bit typed = 1'b0,
                           fmpf_pkg::result_t want = '0);
    int unsigned       gap;
    bit                taken;
    fmpf_pkg::result_t predicted;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    cmd_i          <= c;
    src_addr_i     <= p.src_addr;
    src_addr_any_i <= p.src_addr_any;
    dst_addr_i     <= p.dst_addr;
    dst_addr_any_i <= p.dst_addr_any;
    sport_i        <= p.sport;
    sport_any_i    <= p.sport_any;
    dport_i        <= p.dport;
    dport_any_i    <= p.dport_any;
    protocol_i     <= p.proto;
    protocol_any_i <= p.proto_any;
    rule_action_i  <= p.action;
    // busy_o is sampled at the falling edge, where it already holds the value
    // the block uses at the next rising edge.
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end while (!taken);
    predicted = classify_beat(c, p);
    pending_verdicts.push_back(typed ? want : predicted);
  endtask

  // Holds the sender off until every owed result beat has come back.
  task automatic wait_until_drained();
    start_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  function automatic void flag_mismatch(string what, fmpf_pkg::result_t want,
                                        fmpf_pkg::result_t got);
    mismatch_total++;
    if (mismatch_total <= MaxReported)
      $display("%0t ns %s: expected m/v/s=%0b%0b%0b, got m/v/s=%0b%0b%0b",
               $time, what, want.matched, want.verdict, want.status,
               got.matched, got.verdict, got.status);
  endfunction

  // Result checker: every strobed beat is paired with the oldest expectation.
  // It samples mid-cycle, while the registered result ports are stable.
  always @(negedge clk_i) begin : check_results
    fmpf_pkg::result_t got;
    fmpf_pkg::result_t want;
    if (rst_ni && result_valid_o) begin
      got = '{matched: matched_o, verdict: verdict_o, status: status_o};
      if (pending_verdicts.size() == 0) begin
        flag_mismatch("unexpected result beat", '0, got);
      end else begin
        want = pending_verdicts.pop_front();
        if (got.matched !== want.matched || got.verdict !== want.verdict ||
            got.status !== want.status)
          flag_mismatch("result beat mismatch", want, got);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    plan_entry_t     plan [$];
    fmpf_pkg::rule_t rule_a;
    fmpf_pkg::rule_t rule_b;
    fmpf_pkg::rule_t rule_c;
    fmpf_pkg::rule_t rule_d;
    fmpf_pkg::rule_t udp_probe;
    fmpf_pkg::rule_t web_probe;
    int unsigned     items;
    int unsigned     phase;
    int unsigned     target;
    int unsigned     appended;
    int unsigned     span;
    int unsigned     roll;

    // Rules A and B take opposite extreme values in every address and port field
    // and rule B is ICMP; rule C compares ports only, rule D wildcards its source port.
    rule_a = mk_rule(32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 16'hFFFF, 1'b0, 16'h0, 1'b0,
                     8'hFF, 1'b0, 1'b1);
    rule_b = mk_rule(32'h0, 1'b0, 32'hFFFF_FFFF, 1'b0, 16'h0, 1'b0, 16'hFFFF, 1'b0,
                     fmpf_pkg::ProtoIcmp, 1'b0, 1'b0);
    rule_c = mk_rule(32'h0A00_0001, 1'b1, 32'h0A00_0002, 1'b1, 16'd80, 1'b0, 16'd443,
                     1'b0, ProtoTcp, 1'b1, 1'b1);
    rule_d = mk_rule(32'h0A00_0005, 1'b0, 32'h0A00_0006, 1'b0, 16'd1, 1'b1, 16'd6,
                     1'b0, ProtoUdp, 1'b0, 1'b0);
    udp_probe = mk_rule(32'h0A00_0005, 1'b0, 32'h0A00_0006, 1'b0, 16'd5, 1'b0, 16'd6,
                        1'b0, ProtoUdp, 1'b0, 1'b0);
    web_probe = mk_rule(32'h0A00_0005, 1'b0, 32'h0A00_0006, 1'b0, 16'd80, 1'b0,
                        16'd443, 1'b0, ProtoUdp, 1'b0, 1'b0);

    // A check on the empty table after reset, with every bit set.
    plan.push_back(plan_entry(fmpf_pkg::CMD_CHECK,
                              mk_rule('1, 1'b1, '1, 1'b1, '1, 1'b1, '1, 1'b1,
                                      '1, 1'b1, 1'b1), 1'b1, NoHit));
    // The unused command must leave the table untouched.
    plan.push_back(plan_entry(fmpf_pkg::CMD_NONE, rule_a, 1'b1, NoHit));
    plan.push_back(plan_entry(fmpf_pkg::CMD_CHECK, rule_a, 1'b1, NoHit));
    plan.push_back(plan_entry(fmpf_pkg::CMD_CLEAR, '0, 1'b1, NoHit));
    plan.push_back(plan_entry(fmpf_pkg::CMD_APPEND, rule_a, 1'b1, NoHit));
    // Wildcard bits on a check are ignored: exact hit on rule A, drop.
    plan.push_back(plan_entry(fmpf_pkg::CMD_CHECK,
                              mk_rule(32'hFFFF_FFFF, 1'b1, 32'h0, 1'b1, 16'hFFFF, 1'b1,
                                      16'h0, 1'b1, 8'hFF, 1'b1, 1'b0), 1'b1, HitDrop));
    plan.push_back(plan_entry(fmpf_pkg::CMD_CHECK,
                              mk_rule(32'h0, 1'b0, 32'h0, 1'b0, 16'hFFFF, 1'b0,
                                      16'h0, 1'b0, 8'hFF, 1'b0, 1'b0), 1'b0, NoHit));
    plan.push_back(plan_entry(fmpf_pkg::CMD_CHECK,
                              mk_rule(32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 16'hFFFF, 1'b0,
                                      16'hFFFF, 1'b0, 8'hFF, 1'b0, 1'b0), 1'b0, NoHit));
    plan.push_back(plan_entry(fmpf_pkg::CMD_APPEND, rule_b, 1'b1, NoHit));
    // ICMP packet: ports differ from rule B but are not compared.
    plan.push_back(plan_entry(fmpf_pkg::CMD_CHECK,
                              mk_rule(32'h0, 1'b0, 32'hFFFF_FFFF, 1'b0, 16'd1234, 1'b0,
                                      16'd4321, 1'b0, fmpf_pkg::ProtoIcmp, 1'b0, 1'b0),
                              1'b0, NoHit));
    plan.push_back(plan_entry(fmpf_pkg::CMD_CHECK,
                              mk_rule(32'h0, 1'b0, 32'hFFFF_FFFF, 1'b0, 16'd1234, 1'b0,
                                      16'd4321, 1'b0, ProtoTcp, 1'b0, 1'b0),
                              1'b0, NoHit));
    plan.push_back(plan_entry(fmpf_pkg::CMD_APPEND, rule_c, 1'b1, NoHit));
    // ICMP again, against a rule that only names ports.
    plan.push_back(plan_entry(fmpf_pkg::CMD_CHECK,
                              mk_rule(32'h0A00_0005, 1'b0, 32'h0A00_0006, 1'b0, 16'd5,
                                      1'b0, 16'd6, 1'b0, fmpf_pkg::ProtoIcmp, 1'b0,
                                      1'b0), 1'b0, NoHit));
    plan.push_back(plan_entry(fmpf_pkg::CMD_CHECK, udp_probe, 1'b0, NoHit));
    plan.push_back(plan_entry(fmpf_pkg::CMD_CHECK, web_probe, 1'b0, NoHit));
    web_probe.dport = 16'd444;
    plan.push_back(plan_entry(fmpf_pkg::CMD_CHECK, web_probe, 1'b0, NoHit));
    plan.push_back(plan_entry(fmpf_pkg::CMD_APPEND, rule_d, 1'b1, NoHit));
    plan.push_back(plan_entry(fmpf_pkg::CMD_CHECK, udp_probe, 1'b0, NoHit));
    plan.push_back(plan_entry(fmpf_pkg::CMD_CLEAR, '1, 1'b1, NoHit));
    plan.push_back(plan_entry(fmpf_pkg::CMD_CHECK, udp_probe, 1'b1, NoHit));
    // A rule that is wildcard everywhere catches any packet.
    plan.push_back(plan_entry(fmpf_pkg::CMD_APPEND, '1, 1'b1, NoHit));
    plan.push_back(plan_entry(fmpf_pkg::CMD_CHECK, '0, 1'b1, HitDrop));
    plan.push_back(plan_entry(fmpf_pkg::CMD_NONE, '0, 1'b1, NoHit));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) send_beat(plan[i].cmd, plan[i].pkt, plan[i].typed, plan[i].want);
    wait_until_drained();

    // Random part: each phase clears the table and builds a fresh rule set,
    // usually small, sometimes past the depth so that appends are refused,
    // with checks spread among the appends.
    items = 0;
    phase = 0;
    while (items < RandomItems) begin
      idle_on = ($urandom_range(0, 3) != 0);
      target = ($urandom_range(0, 3) == 0) ? RuleDepth + $urandom_range(1, 6)
                                           : $urandom_range(1, 16);
      span = 2 * target + $urandom_range(5, 20);
      appended = 0;
      send_beat(fmpf_pkg::CMD_CLEAR, random_rule());
      items++;
      for (int unsigned n = 0; n < span; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          send_beat(fmpf_pkg::CMD_NONE, random_rule());
        end else begin
          if (appended < target && roll < 60) begin
            send_beat(fmpf_pkg::CMD_APPEND, random_rule());
            appended++;
          end else if (rule_total > 0 && roll < 85) begin
            send_beat(fmpf_pkg::CMD_CHECK, packet_near_rule());
          end else begin
            send_beat(fmpf_pkg::CMD_CHECK, random_rule());
          end
          items++;
        end
      end
      phase++;
      if (phase % 4 == 0) wait_until_drained();
    end

    // A full table must refuse any further append whatever its content.
    while (rule_total < RuleDepth) send_beat(fmpf_pkg::CMD_APPEND, random_rule());
    send_beat(fmpf_pkg::CMD_APPEND, random_rule(), 1'b1, TableFull);

    wait_until_drained();
    repeat (RuleDepth + 8) @(posedge clk_i);
    if (mismatch_total == 0 && pending_verdicts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
